FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

FILE: hdl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared constants and types of the LFU cache table.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int CAP_DEF  = 16;
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int CNT_W    = 32;
  localparam int STAMP_W  = 64;
  localparam int CAPREG_W = 5;

  localparam logic [CAPREG_W-1:0] CAPACITY_RST = 5'd16;
  localparam logic [CNT_W-1:0]    CNT_MAX      = '1;

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]   tag;
    logic [VAL_W-1:0]   data;
    logic [CNT_W-1:0]   cnt;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic occ_zero;
    logic scan_last;
    logic out_free;
  } stat_t;

endpackage

FILE: hdl/lfu_ctrl.sv
// ----------------------------------------------------------------------------
// lfu_ctrl
// Request sequencer: load, scan the occupied entries, commit.
// ----------------------------------------------------------------------------
module lfu_ctrl
  import lfu_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_WRITE = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = stat.occ_zero ? S_WRITE : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd = 1'b1;
        if (stat.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_WRITE;
      end
      S_WRITE: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/lfu_dp.sv
// ----------------------------------------------------------------------------
// lfu_dp
// Entry memory, scan trackers, replacement choice and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module lfu_dp
  import lfu_pkg::*;
#(
  parameter int CAP = CAP_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output stat_t               stat,
  input  logic                mode,
  input  logic [KEY_W-1:0]    lookup_key,
  input  logic [VAL_W-1:0]    write_value,
  input  logic                cfg_we,
  input  logic [CAPREG_W-1:0] cfg_capacity,
  input  logic                out_ready,
  output logic                out_valid,
  output logic                hit,
  output logic [VAL_W-1:0]    read_value,
  output logic                evicted,
  output logic [KEY_W-1:0]    evicted_key
);

  localparam int IW = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int OW = $clog2(CAP + 1);
  localparam int CW = (OW > CAPREG_W) ? OW : CAPREG_W;
  localparam logic [CW-1:0] CAP_CW = CW'(CAP);

  entry_t mem [CAP];
  entry_t rdata;

  logic                mode_r;
  logic [KEY_W-1:0]    key_r;
  logic [VAL_W-1:0]    val_r;
  logic [CAPREG_W-1:0] capacity;
  logic [OW-1:0]       occ;
  logic [STAMP_W-1:0]  clock_r;
  logic [IW-1:0]       idx;
  logic [IW-1:0]       rd_idx;
  logic                rd_pend;

  logic                found;
  logic [IW-1:0]       found_idx;
  logic [CNT_W-1:0]    found_cnt;
  logic [VAL_W-1:0]    found_data;
  logic                best_have;
  logic [IW-1:0]       best_idx;
  logic [CNT_W-1:0]    best_cnt;
  logic [STAMP_W-1:0]  best_stamp;
  logic [KEY_W-1:0]    best_tag;

  logic [CW-1:0]       eff_cap;
  logic                has_room;
  logic                better;
  logic                we;
  logic [IW-1:0]       waddr;
  entry_t              wdata;
  logic                o_hit, o_ev;
  logic [VAL_W-1:0]    o_rv;
  logic [KEY_W-1:0]    o_ek;

  always_comb begin
    if (capacity == '0) begin
      eff_cap = CW'(1);
    end else if (CW'(capacity) > CAP_CW) begin
      eff_cap = CAP_CW;
    end else begin
      eff_cap = CW'(capacity);
    end
  end

  assign has_room = CW'(occ) < eff_cap;
  assign better   = !best_have || (rdata.cnt < best_cnt) ||
                    ((rdata.cnt == best_cnt) && (rdata.stamp < best_stamp));

  assign stat.occ_zero  = (occ == '0);
  assign stat.scan_last = (OW'(idx) == occ - OW'(1));
  assign stat.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RST;
    end else if (cfg_we) begin
      capacity <= cfg_capacity;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= mode;
      key_r  <= lookup_key;
      val_r  <= write_value;
    end
    if (cmd.rd) begin
      rdata  <= mem[idx];
      rd_idx <= idx;
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      rd_pend   <= 1'b0;
      found     <= 1'b0;
      best_have <= 1'b0;
    end else begin
      rd_pend <= cmd.rd;
      if (cmd.load) begin
        idx       <= '0;
        found     <= 1'b0;
        best_have <= 1'b0;
      end else if (cmd.rd) begin
        idx <= idx + IW'(1);
      end
      if (rd_pend) begin
        if (!found && (rdata.tag == key_r)) begin
          found <= 1'b1;
        end
        if (better) begin
          best_have <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend && !found && (rdata.tag == key_r)) begin
      found_idx  <= rd_idx;
      found_cnt  <= rdata.cnt;
      found_data <= rdata.data;
    end
    if (rd_pend && better) begin
      best_idx   <= rd_idx;
      best_cnt   <= rdata.cnt;
      best_stamp <= rdata.stamp;
      best_tag   <= rdata.tag;
    end
  end

  always_comb begin
    we          = 1'b0;
    waddr       = found_idx;
    wdata.tag   = key_r;
    wdata.data  = val_r;
    wdata.cnt   = CNT_W'(1);
    wdata.stamp = clock_r + STAMP_W'(1);
    o_hit       = 1'b0;
    o_rv        = '0;
    o_ev        = 1'b0;
    o_ek        = '0;
    priority if (found) begin
      we        = cmd.commit;
      o_hit     = 1'b1;
      wdata.cnt = (found_cnt == CNT_MAX) ? found_cnt : found_cnt + CNT_W'(1);
      if (mode_r == MODE_GET) begin
        wdata.data = found_data;
        o_rv       = found_data;
      end
    end else if (mode_r == MODE_GET) begin
      we = 1'b0;
    end else if (has_room) begin
      we    = cmd.commit;
      waddr = occ[IW-1:0];
    end else begin
      we    = cmd.commit;
      waddr = best_idx;
      o_ev  = 1'b1;
      o_ek  = best_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      clock_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
        if (we) begin
          clock_r <= clock_r + STAMP_W'(1);
        end
        if (we && !found && has_room) begin
          occ <= occ + OW'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit         <= o_hit;
      read_value  <= o_rv;
      evicted     <= o_ev;
      evicted_key <= o_ek;
    end
  end

  `ASSERT_CLK(a_commit_out, clk, rst, cmd.commit |=> out_valid, "commit left no result")
  `ASSERT_CLK(a_occ_step, clk, rst, (occ != $past(occ)) |-> (occ == $past(occ) + OW'(1)), "occupancy jumped")
  `ASSERT_NEVER(a_commit_busy, clk, rst, cmd.commit && out_valid && !out_ready, "result overwritten")

endmodule

FILE: hdl/lfu_cache_table_core.sv
// ----------------------------------------------------------------------------
// lfu_cache_table_core
// Fully associative key/value cache, LFU replacement with LRU tie-break.
// ----------------------------------------------------------------------------
// channel  dir  transfer when
// s_*      in   s_tvalid & s_tready   get/put request
// m_*      out  m_tvalid & m_tready   result
// cfg_*    in   cfg_valid & cfg_ready capacity write
//
// A request reads one entry per cycle from the single-port entry memory
// (no reads with an empty table), then compares and commits.
// The result register lets a new request enter while a result waits.
// Reset clears occupancy, the recency clock and the result valid.
// ----------------------------------------------------------------------------
module lfu_cache_table_core
  import lfu_pkg::*;
#(
  parameter int CAP = CAP_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [63:0]         s_tdata,   // lookup_key, write_value
  input  logic [0:0]          s_tuser,   // mode
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [63:0]         m_tdata,   // read_value, evicted_key
  output logic [1:0]          m_tuser,   // hit, evicted
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CAPREG_W-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  logic                o_hit, o_ev;
  logic [VAL_W-1:0]    o_rv;
  logic [KEY_W-1:0]    o_ek;

  assign cfg_ready = 1'b1;

  lfu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lfu_dp #(
    .CAP (CAP)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .mode         (s_tuser[0]),
    .lookup_key   (s_tdata[31:0]),
    .write_value  (s_tdata[63:32]),
    .cfg_we       (cfg_valid & cfg_ready),
    .cfg_capacity (cfg_data),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .hit          (o_hit),
    .read_value   (o_rv),
    .evicted      (o_ev),
    .evicted_key  (o_ek)
  );

  assign m_tdata = {o_ek, o_rv};
  assign m_tuser = {o_ev, o_hit};

endmodule
